>>> sv/crma_pkg.sv
`default_nettype none

package crma_pkg;

  // Default sizes of the condition table, the mode mask and the channel store.
  localparam int NUM_CONDITIONS_DEF   = 40;
  localparam int NUM_MODES_DEF        = 64;
  localparam int NUM_AUX_CHANNELS_DEF = 16;

  // Fixed field widths.
  localparam int ACTION_W    = 2;
  localparam int ENTRY_W     = 6;
  localparam int MODE_W      = 6;
  localparam int CHAN_W      = 4;
  localparam int STEP_W      = 6;
  localparam int VALUE_W     = 12;
  localparam int MASK_W      = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int BASE_W      = 12;
  localparam int WIDTH_W     = 8;
  localparam int PROD_W      = STEP_W + WIDTH_W;
  localparam int BOUND_W     = PROD_W + 1;

  // Register reset values.
  localparam logic [BASE_W-1:0]  RANGE_BASE_RST = BASE_W'(900);
  localparam logic [WIDTH_W-1:0] STEP_WIDTH_RST = WIDTH_W'(25);

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_EVAL   = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AND_LOGIC  = 2'd0,
    CFG_RANGE_BASE = 2'd1,
    CFG_STEP_WIDTH = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_FINISH
  } state_t;

  // One stored activation condition.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAN_W-1:0] chan;
    logic [STEP_W-1:0] start;
    logic [STEP_W-1:0] stop;
  } cond_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic issue;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic res_block;
  } sts_t;

  // Address width for a store of n entries, at least one bit.
  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

>>> sv/crma_ifs.sv
`default_nettype none

interface crma_item_if;
  logic                          valid;
  logic                          ready;
  logic [crma_pkg::ACTION_W-1:0] action;
  logic [crma_pkg::ENTRY_W-1:0]  entry_index;
  logic [crma_pkg::MODE_W-1:0]   mode_number;
  logic [crma_pkg::CHAN_W-1:0]   aux_channel;
  logic [crma_pkg::STEP_W-1:0]   start_step;
  logic [crma_pkg::STEP_W-1:0]   end_step;
  logic [crma_pkg::VALUE_W-1:0]  channel_value;

  modport source (output valid, action, entry_index, mode_number, aux_channel,
                  start_step, end_step, channel_value, input ready);
  modport sink   (input valid, action, entry_index, mode_number, aux_channel,
                  start_step, end_step, channel_value, output ready);
endinterface

interface crma_result_if;
  logic                        valid;
  logic                        ready;
  logic [crma_pkg::MASK_W-1:0] mode_mask;

  modport source (output valid, mode_mask, input ready);
  modport sink   (input valid, mode_mask, output ready);
endinterface

interface crma_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [crma_pkg::CFG_IDX_W-1:0]  index;
  logic [crma_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/channel_range_mode_activation_top.sv
`default_nettype none

// Channel   Role    Handshake     Payload
// item      sink    valid/ready   action, entry_index, mode_number, aux_channel,
//                                 start_step, end_step, channel_value
// result    source  valid/ready   mode_mask
// cfg       sink    valid/ready   index, data (and_logic, range_base, step_width)
//
// Write and update beats produce no result.
// An evaluate beat reads the table once per condition entry through the single
// memory read port, then drains through the DRAIN1, DRAIN2 and FINISH states.
// Reset clears the table valid bits and the channel store and returns the registers to their reset values.
// A stalled result holds in the output register; the next beat is still taken,
// and a following evaluate waits in its last cycle until the register frees.
module channel_range_mode_activation_top #(
  parameter int NUM_CONDITIONS   = crma_pkg::NUM_CONDITIONS_DEF,
  parameter int NUM_MODES        = crma_pkg::NUM_MODES_DEF,
  parameter int NUM_AUX_CHANNELS = crma_pkg::NUM_AUX_CHANNELS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  crma_item_if.sink     item,
  crma_result_if.source result,
  crma_cfg_if.sink      cfg
);
  import crma_pkg::*;

  localparam int IDX_W = idx_width(NUM_CONDITIONS);

  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] rd_addr;
  logic             item_ready;
  logic             item_acc;
  logic             cfg_acc;

  // Configuration writes are always taken; the user must send them only while idle, as the block does not enforce it.
  assign cfg.ready  = 1'b1;
  assign cfg_acc    = cfg.valid;
  assign item.ready = item_ready;
  assign item_acc   = item.valid && item_ready;

  // The controller walks the table once per evaluate beat.
  crma_ctrl #(
    .NUM_CONDITIONS(NUM_CONDITIONS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_action(item.action),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd),
    .rd_addr    (rd_addr)
  );

  // The datapath holds the stores and the range test pipeline.
  crma_datapath #(
    .NUM_CONDITIONS  (NUM_CONDITIONS),
    .NUM_MODES       (NUM_MODES),
    .NUM_AUX_CHANNELS(NUM_AUX_CHANNELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item_acc     (item_acc),
    .action       (item.action),
    .entry_index  (item.entry_index),
    .mode_number  (item.mode_number),
    .aux_channel  (item.aux_channel),
    .start_step   (item.start_step),
    .end_step     (item.end_step),
    .channel_value(item.channel_value),
    .cfg_acc      (cfg_acc),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .sts          (sts),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .mode_mask    (result.mode_mask)
  );

endmodule

`default_nettype wire

>>> sv/crma_ctrl.sv
`default_nettype none

module crma_ctrl #(
  parameter int NUM_CONDITIONS = crma_pkg::NUM_CONDITIONS_DEF
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst,
  input  wire logic                                             item_valid,
  input  wire logic [crma_pkg::ACTION_W-1:0]                    item_action,
  output logic                                                  item_ready,
  input  wire crma_pkg::sts_t                                   sts,
  output crma_pkg::cmd_t                                        cmd,
  output logic [crma_pkg::idx_width(NUM_CONDITIONS)-1:0]        rd_addr
);
  import crma_pkg::*;

  localparam int IDX_W = idx_width(NUM_CONDITIONS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_CONDITIONS - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic             start_eval;

  assign start_eval = item_valid && (item_action == ACT_EVAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (start_eval) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == LAST) begin
          state_next = ST_DRAIN1;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!sts.res_block) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    cmd        = '0;
    rd_addr    = cnt;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.clear  = start_eval;
      end
      ST_SCAN:   cmd.issue = 1'b1;
      ST_DRAIN1: cmd = '0;
      ST_DRAIN2: cmd = '0;
      ST_FINISH: cmd.load = !sts.res_block;
      default:   cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/crma_datapath.sv
`default_nettype none

module crma_datapath #(
  parameter int NUM_CONDITIONS   = crma_pkg::NUM_CONDITIONS_DEF,
  parameter int NUM_MODES        = crma_pkg::NUM_MODES_DEF,
  parameter int NUM_AUX_CHANNELS = crma_pkg::NUM_AUX_CHANNELS_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         item_acc,
  input  wire logic [crma_pkg::ACTION_W-1:0]                action,
  input  wire logic [crma_pkg::ENTRY_W-1:0]                 entry_index,
  input  wire logic [crma_pkg::MODE_W-1:0]                  mode_number,
  input  wire logic [crma_pkg::CHAN_W-1:0]                  aux_channel,
  input  wire logic [crma_pkg::STEP_W-1:0]                  start_step,
  input  wire logic [crma_pkg::STEP_W-1:0]                  end_step,
  input  wire logic [crma_pkg::VALUE_W-1:0]                 channel_value,
  input  wire logic                                         cfg_acc,
  input  wire logic [crma_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  wire logic [crma_pkg::CFG_DATA_W-1:0]              cfg_data,
  input  wire crma_pkg::cmd_t                               cmd,
  input  wire logic [crma_pkg::idx_width(NUM_CONDITIONS)-1:0] rd_addr,
  output crma_pkg::sts_t                                    sts,
  output logic                                              res_valid,
  input  wire logic                                         res_ready,
  output logic [crma_pkg::MASK_W-1:0]                       mode_mask
);
  import crma_pkg::*;

  localparam int IDX_W = idx_width(NUM_CONDITIONS);
  localparam int CH_W  = idx_width(NUM_AUX_CHANNELS);

  // Configuration registers.
  logic               and_logic;
  logic [BASE_W-1:0]  range_base;
  logic [WIDTH_W-1:0] step_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      and_logic  <= 1'b0;
      range_base <= RANGE_BASE_RST;
      step_width <= STEP_WIDTH_RST;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        CFG_AND_LOGIC:  and_logic  <= cfg_data[0];
        CFG_RANGE_BASE: range_base <= cfg_data[BASE_W-1:0];
        CFG_STEP_WIDTH: step_width <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Condition table: memory plus one valid bit per entry.
  cond_t                   cond_mem [NUM_CONDITIONS];
  logic [NUM_CONDITIONS-1:0] cond_vld;
  logic                    wr_cond;
  cond_t                   wr_data;

  assign wr_cond = item_acc && (action == ACT_WRITE) &&
                   ({1'b0, entry_index} < 7'(NUM_CONDITIONS));
  assign wr_data = '{mode: mode_number, chan: aux_channel,
                     start: start_step, stop: end_step};

  always_ff @(posedge clk) begin
    if (wr_cond) cond_mem[entry_index[IDX_W-1:0]] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cond_vld <= '0;
    end else if (wr_cond) begin
      cond_vld[entry_index[IDX_W-1:0]] <= 1'b1;
    end
  end

  // Channel store.
  logic [VALUE_W-1:0] chan_store [NUM_AUX_CHANNELS];
  logic               wr_chan;

  assign wr_chan = item_acc && (action == ACT_UPDATE) &&
                   ({1'b0, aux_channel} < 5'(NUM_AUX_CHANNELS));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AUX_CHANNELS; i++) chan_store[i] <= '0;
    end else if (wr_chan) begin
      chan_store[aux_channel[CH_W-1:0]] <= channel_value;
    end
  end

  // Stage 1: registered table read.
  cond_t rd_q;
  logic  rd_vld_q;
  logic  s1_v;

  always_ff @(posedge clk) begin
    rd_q     <= cond_mem[rd_addr];
    rd_vld_q <= cond_vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else     s1_v <= cmd.issue;
  end

  cond_t cur;
  logic  cur_usable, cur_chan_ok;

  assign cur         = rd_vld_q ? rd_q : '0;
  assign cur_usable  = ({1'b0, cur.mode} < 7'(NUM_MODES)) && (cur.start < cur.stop);
  assign cur_chan_ok = {1'b0, cur.chan} < 5'(NUM_AUX_CHANNELS);

  // Stage 2: range products and channel value.
  logic               s2_v, s2_usable, s2_chan_ok;
  logic [MODE_W-1:0]  s2_mode;
  logic [VALUE_W-1:0] s2_val;
  logic [PROD_W-1:0]  s2_lo_p, s2_hi_p;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else     s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    s2_usable  <= cur_usable;
    s2_chan_ok <= cur_chan_ok;
    s2_mode    <= cur.mode;
    s2_val     <= chan_store[cur.chan[CH_W-1:0]];
    s2_lo_p    <= PROD_W'(cur.start) * PROD_W'(step_width);
    s2_hi_p    <= PROD_W'(cur.stop) * PROD_W'(step_width);
  end

  logic [BOUND_W-1:0] lo, hi;
  logic               hit;

  assign lo  = BOUND_W'(range_base) + BOUND_W'(s2_lo_p);
  assign hi  = BOUND_W'(range_base) + BOUND_W'(s2_hi_p);
  assign hit = s2_chan_ok && (BOUND_W'(s2_val) >= lo) && (BOUND_W'(s2_val) < hi);

  // Per-mode summaries: usable, some active, some inactive.
  logic [NUM_MODES-1:0] usable_bits, hit_bits, miss_bits, eval_mask;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      usable_bits <= '0;
      hit_bits    <= '0;
      miss_bits   <= '0;
    end else if (s2_v && s2_usable) begin
      for (int m = 0; m < NUM_MODES; m++) begin
        if (s2_mode == MODE_W'(m)) begin
          usable_bits[m] <= 1'b1;
          if (hit) hit_bits[m]  <= 1'b1;
          else     miss_bits[m] <= 1'b1;
        end
      end
    end
  end

  assign eval_mask = and_logic ? (usable_bits & ~miss_bits) : hit_bits;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) mode_mask <= MASK_W'(eval_mask);
  end

  assign sts.res_block = res_valid && !res_ready;

endmodule

`default_nettype wire

>>> sv/crma_checker.sv
`default_nettype none

module crma_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            item_valid,
  input wire logic                            item_ready,
  input wire logic [crma_pkg::ACTION_W-1:0]   item_action,
  input wire logic                            res_valid,
  input wire logic                            res_ready,
  input wire logic [crma_pkg::MASK_W-1:0]     res_mask
);
  import crma_pkg::*;

  logic item_acc;
  assign item_acc = item_valid && item_ready;

  // A result that is not taken stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // A stalled mask does not change.
  a_mask_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_mask))
    else $error("result mask changed while stalled");

  // An evaluate beat occupies the block for the next cycle.
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    item_acc && (item_action == ACT_EVAL) |=> !item_ready)
    else $error("input taken during evaluation");

  // Writes and updates never raise a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    item_acc && (item_action != ACT_EVAL) && !res_valid |=> !res_valid)
    else $error("result without evaluate");

endmodule

bind channel_range_mode_activation_top crma_checker u_crma_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .item_action(item.action),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_mask   (result.mode_mask)
);

`default_nettype wire

>>> dv/channel_range_mode_activation_top_tb.sv
`timescale 1ns / 100ps

module channel_range_mode_activation_top_tb;
  import crma_pkg::*;

  localparam int N_COND = NUM_CONDITIONS_DEF;
  localparam int N_MODE = NUM_MODES_DEF;
  localparam int N_CHAN = NUM_AUX_CHANNELS_DEF;

  // Action code 3 is not decoded by the block; beats carrying it are dropped.
  localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 4;
  // An evaluation walks the whole table and then drains a short pipeline, so
  // this many quiet cycles are enough for any beat in flight to settle.
  localparam int DRAIN_CYCLES   = N_COND + 12;
  localparam int HOLDOFF_CYCLES = 500;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_BEATS    = 110;
  localparam int NUM_PHASES     = 7;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [ENTRY_W-1:0]  entry;
    logic [MODE_W-1:0]   mode;
    logic [CHAN_W-1:0]   chan;
    logic [STEP_W-1:0]   lo_step;
    logic [STEP_W-1:0]   hi_step;
    logic [VALUE_W-1:0]  value;
  } beat_t;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  crma_item_if   item_ch ();
  crma_result_if res_ch ();
  crma_cfg_if    cfg_ch ();

  channel_range_mode_activation_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // Shadow copy of the block's state and registers, advanced beat by beat as
  // the block accepts them.
  cond_t            cond_table [N_COND];
  logic [VALUE_W-1:0] chan_values [N_CHAN];
  logic             and_reg;
  logic [BASE_W-1:0]  base_reg;
  logic [WIDTH_W-1:0] step_reg;

  // Mode masks still owed by the block, oldest first.
  logic [MASK_W-1:0] pending_masks [$];
  logic [MASK_W-1:0] owed_mask;

  // Traffic shaping knobs, set by the test tasks.
  bit        sender_gaps = 1'b0;
  int        burst_left  = 0;
  rx_style_t rx_style    = RX_ALWAYS;
  int        holdoff_reqs = 0;

  int mismatches = 0;
  int n_writes = 0, n_updates = 0, n_evals = 0, n_ignored = 0, n_settings = 0;
  int n_results = 0, n_active_results = 0;

  // Mode mask for the current table, channel values and registers. A mode
  // counts only if it has at least one condition with a non-empty step range.
  function automatic logic [MASK_W-1:0] predict_mode_mask();
    int usable [N_MODE];
    int active [N_MODE];
    int lo_bound, hi_bound, v;
    logic [MASK_W-1:0] mask;
    mask = '0;
    for (int m = 0; m < N_MODE; m++) begin
      usable[m] = 0;
      active[m] = 0;
    end
    for (int i = 0; i < N_COND; i++) begin
      if (cond_table[i].start < cond_table[i].stop) begin
        usable[cond_table[i].mode]++;
        v        = int'(chan_values[cond_table[i].chan]);
        lo_bound = int'(base_reg) + int'(cond_table[i].start) * int'(step_reg);
        hi_bound = int'(base_reg) + int'(cond_table[i].stop) * int'(step_reg);
        if (v >= lo_bound && v < hi_bound) active[cond_table[i].mode]++;
      end
    end
    for (int m = 0; m < N_MODE; m++) begin
      if (usable[m] != 0) begin
        if (and_reg) mask[m] = (active[m] == usable[m]);
        else         mask[m] = (active[m] > 0);
      end
    end
    return mask;
  endfunction

  // Advances the shadow state by one accepted beat.
  function automatic void apply_beat(input beat_t b);
    case (b.act)
      ACT_WRITE: begin
        if (b.entry < N_COND) begin
          cond_table[b.entry] = '{mode: b.mode, chan: b.chan, start: b.lo_step,
                                  stop: b.hi_step};
          n_writes++;
        end else begin
          n_ignored++;
        end
      end
      ACT_UPDATE: begin
        chan_values[b.chan] = b.value;
        n_updates++;
      end
      ACT_EVAL: begin
        pending_masks.push_back(predict_mode_mask());
        n_evals++;
      end
      default: n_ignored++;
    endcase
  endfunction

  function automatic beat_t mk_item(input logic [ACTION_W-1:0] act, input int entry,
                                    input int mode, input int chan, input int lo,
                                    input int hi, input int value);
    beat_t b;
    b.act     = act;
    b.entry   = entry[ENTRY_W-1:0];
    b.mode    = mode[MODE_W-1:0];
    b.chan    = chan[CHAN_W-1:0];
    b.lo_step = lo[STEP_W-1:0];
    b.hi_step = hi[STEP_W-1:0];
    b.value   = value[VALUE_W-1:0];
    return b;
  endfunction

  // Every field random; fields the action does not use are still toggled.
  function automatic beat_t rand_fields(input logic [ACTION_W-1:0] act);
    return mk_item(act, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 15), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 4095));
  endfunction

  // Condition writes favor a few modes and channels so that modes collect
  // several conditions, and mostly carry non-empty ranges.
  function automatic beat_t rand_write();
    beat_t b;
    int sel;
    b   = rand_fields(ACT_WRITE);
    sel = $urandom_range(0, 9);
    b.entry = ($urandom_range(0, 11) == 0) ? ENTRY_W'($urandom_range(N_COND, 63))
                                           : ENTRY_W'($urandom_range(0, N_COND - 1));
    b.mode  = (sel < 6) ? MODE_W'($urandom_range(0, 3))
            : (sel < 8) ? MODE_W'($urandom_range(60, 63)) : MODE_W'($urandom_range(0, 63));
    b.chan  = ($urandom_range(0, 9) < 7) ? CHAN_W'($urandom_range(0, 3))
                                         : CHAN_W'($urandom_range(0, 15));
    b.lo_step = STEP_W'($urandom_range(0, 40));
    b.hi_step = ($urandom_range(0, 4) != 0) ? STEP_W'(b.lo_step + $urandom_range(1, 23))
                                            : STEP_W'($urandom_range(0, b.lo_step));
    return b;
  endfunction

  // Channel updates aim at the bounds of a condition already in the table.
  function automatic beat_t rand_update();
    beat_t b;
    cond_t c;
    int lo_bound, hi_bound, target;
    b = rand_fields(ACT_UPDATE);
    c = cond_table[$urandom_range(0, N_COND - 1)];
    lo_bound = int'(base_reg) + int'(c.start) * int'(step_reg);
    hi_bound = int'(base_reg) + int'(c.stop) * int'(step_reg);
    case ($urandom_range(0, 5))
      0: target = lo_bound - 1;
      1: target = lo_bound;
      2: target = hi_bound - 1;
      3: target = hi_bound;
      4: target = (hi_bound > lo_bound) ? lo_bound + $urandom_range(0, hi_bound - lo_bound - 1)
                                        : lo_bound;
      default: target = $urandom_range(0, 4095);
    endcase
    if (target < 0 || target > 4095) target = $urandom_range(0, 4095);
    if ($urandom_range(0, 3) != 0) b.chan = c.chan;
    b.value = target[VALUE_W-1:0];
    return b;
  endfunction

  // Offers one beat and returns in the time step of its acceptance, unless a gap
  // follows. Valid is left high so that back-to-back beats need only one
  // assignment per step; with sender gaps on, a gap is inserted when a burst runs out.
  task automatic send_beat(input beat_t b);
    int gap;
    item_ch.valid         <= 1'b1;
    item_ch.action        <= b.act;
    item_ch.entry_index   <= b.entry;
    item_ch.mode_number   <= b.mode;
    item_ch.aux_channel   <= b.chan;
    item_ch.start_step    <= b.lo_step;
    item_ch.end_step      <= b.hi_step;
    item_ch.channel_value <= b.value;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    apply_beat(b);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Waits until every owed mask is in and the block has gone quiet.
  task automatic drain_block();
    item_ch.valid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      CFG_AND_LOGIC:  and_reg  = data[0];
      CFG_RANGE_BASE: base_reg = data[BASE_W-1:0];
      CFG_STEP_WIDTH: step_reg = data[WIDTH_W-1:0];
      default: ;
    endcase
  endtask

  // Loads all three registers once the block is idle. Unused upper data bits
  // carry noise, since the block must ignore them.
  task automatic set_registers(input bit and_val, input logic [BASE_W-1:0] base_val,
                               input logic [WIDTH_W-1:0] step_val);
    logic [CFG_DATA_W-1:0] noise;
    drain_block();
    noise = CFG_DATA_W'($urandom_range(0, 4095));
    write_register(CFG_AND_LOGIC, {noise[CFG_DATA_W-1:1], and_val});
    write_register(CFG_RANGE_BASE, base_val);
    write_register(CFG_STEP_WIDTH, {noise[CFG_DATA_W-1:WIDTH_W], step_val});
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // Reset defaults under OR logic: empty table, inclusive lower and exclusive
  // upper bounds, writes past the table, empty and inverted ranges, and the
  // extreme entry, mode, channel and value.
  task automatic test_defaults_directed();
    sender_gaps = 1'b0;
    rx_style    = RX_ALWAYS;
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(ACT_RESERVED, 63, 63, 15, 63, 63, 4095));
    send_beat(mk_item(ACT_WRITE, 0, 0, 0, 0, 63, 0));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 0, 0, 0, 900));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 0, 0, 0, 899));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(ACT_WRITE, 39, 63, 15, 62, 63, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 15, 0, 0, 2474));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 15, 0, 0, 2475));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    // Writes past the table must not land anywhere.
    send_beat(mk_item(ACT_WRITE, N_COND, 63, 15, 0, 63, 0));
    send_beat(mk_item(ACT_WRITE, 63, 62, 15, 0, 63, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 15, 0, 0, 1000));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    // Equal and inverted bounds make a condition unusable.
    send_beat(mk_item(ACT_WRITE, 1, 1, 1, 5, 5, 0));
    send_beat(mk_item(ACT_WRITE, 2, 2, 2, 10, 3, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 1, 0, 0, 1025));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 2, 0, 0, 1100));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 0, 0, 0, 4095));
    send_beat(mk_item(ACT_EVAL, 63, 63, 15, 63, 63, 4095));
  endtask

  // AND logic: a mode with one idle condition stays off until all its usable
  // conditions are active; an unusable condition of the same mode is ignored.
  task automatic test_and_logic();
    set_registers(1'b1, 900, 25);
    sender_gaps = 1'b1;
    rx_style    = RX_RANDOM;
    send_beat(mk_item(ACT_WRITE, 3, 5, 3, 0, 4, 0));
    send_beat(mk_item(ACT_WRITE, 4, 5, 4, 4, 8, 0));
    send_beat(mk_item(ACT_WRITE, 5, 5, 7, 9, 2, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 3, 0, 0, 950));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 4, 0, 0, 0));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 4, 0, 0, 1000));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 3, 0, 0, 999));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
  endtask

  // Smallest base with unit width, largest base and width, then a zero width that
  // empties every range.
  task automatic test_register_extremes();
    set_registers(1'b0, 0, 1);
    rx_style = RX_PATTERN;
    send_beat(mk_item(ACT_WRITE, 6, 6, 5, 0, 1, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 5, 0, 0, 0));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 5, 0, 0, 1));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    set_registers(1'b1, 4095, 255);
    send_beat(mk_item(ACT_WRITE, 7, 7, 6, 0, 63, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 6, 0, 0, 4095));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    send_beat(mk_item(ACT_UPDATE, 0, 0, 6, 0, 0, 4094));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
    set_registers(1'b0, 4095, 0);
    send_beat(mk_item(ACT_UPDATE, 0, 0, 6, 0, 0, 4095));
    send_beat(mk_item(ACT_EVAL, 0, 0, 0, 0, 0, 0));
  endtask

  // The receiver stops for a long stretch while evaluations keep coming, so
  // the output register fills and the block has to stall its input.
  task automatic test_result_holdoff();
    set_registers(1'b0, 900, 25);
    sender_gaps = 1'b0;
    rx_style    = RX_ALWAYS;
    holdoff_reqs++;
    for (int k = 0; k < 16; k++) begin
      if (k % 2 == 0) send_beat(rand_fields(ACT_EVAL));
      else            send_beat(rand_update());
    end
  endtask

  // Random traffic over several register settings, each phase with its own
  // sender and receiver behavior. Dropped beats do not count toward a phase.
  task automatic test_random_phases();
    bit                 and_tab  [NUM_PHASES] = '{0, 1, 0, 1, 1, 0, 0};
    logic [BASE_W-1:0]  base_tab [NUM_PHASES] = '{900, 900, 0, 4095, 0, 0, 0};
    logic [WIDTH_W-1:0] step_tab [NUM_PHASES] = '{25, 25, 1, 255, 0, 0, 0};
    rx_style_t          rx_tab   [NUM_PHASES] = '{RX_RANDOM, RX_PATTERN, RX_ALWAYS,
                                                  RX_RANDOM, RX_PATTERN, RX_RANDOM,
                                                  RX_ALWAYS};
    bit                 gap_tab  [NUM_PHASES] = '{1, 1, 0, 1, 0, 1, 1};
    logic [BASE_W-1:0]  base_val;
    logic [WIDTH_W-1:0] step_val;
    beat_t b;
    int counted, pick;
    for (int p = 0; p < NUM_PHASES; p++) begin
      base_val = base_tab[p];
      step_val = step_tab[p];
      if (p == 4 || p == 6) begin
        base_val = BASE_W'($urandom_range(0, 4095));
        step_val = WIDTH_W'($urandom_range(1, 255));
      end else if (p == 5) begin
        base_val = BASE_W'($urandom_range(0, 4095));
      end
      set_registers(and_tab[p], base_val, step_val);
      rx_style    = rx_tab[p];
      sender_gaps = gap_tab[p];
      counted     = 0;
      while (counted < PHASE_BEATS) begin
        pick = $urandom_range(0, 99);
        if (pick < 35)      b = rand_write();
        else if (pick < 75) b = rand_update();
        else if (pick < 95) b = rand_fields(ACT_EVAL);
        else                b = rand_fields(ACT_RESERVED);
        send_beat(b);
        if (!(b.act == ACT_RESERVED || (b.act == ACT_WRITE && b.entry >= N_COND)))
          counted++;
      end
    end
  endtask

  // Result receiver: a requested hold-off takes precedence over the style of
  // the current phase.
  initial begin
    int hold_left;
    int holdoff_seen;
    int tick;
    hold_left    = 0;
    holdoff_seen = 0;
    tick         = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (holdoff_reqs != holdoff_seen) begin
        holdoff_seen = holdoff_reqs;
        hold_left    = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_RANDOM:  res_ch.ready <= ($urandom_range(0, 99) < 65);
          RX_PATTERN: res_ch.ready <= ((tick % 7) < 4);
          default:    res_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Every mode mask beat is matched against the oldest owed mask.
  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      n_results++;
      if (pending_masks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mode mask beat with none owed: got %h", res_ch.mode_mask);
      end else begin
        owed_mask = pending_masks.pop_front();
        if (owed_mask != '0) n_active_results++;
        if (res_ch.mode_mask !== owed_mask) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mode mask mismatch: expected %h, got %h", owed_mask,
                     res_ch.mode_mask);
        end
      end
    end
  end

  // Watchdog: too long without any beat on any channel ends the run.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL channel_range_mode_activation_top");
    $finish;
  end

  initial begin
    item_ch.valid         = 1'b0;
    item_ch.action        = ACT_WRITE;
    item_ch.entry_index   = '0;
    item_ch.mode_number   = '0;
    item_ch.aux_channel   = '0;
    item_ch.start_step    = '0;
    item_ch.end_step      = '0;
    item_ch.channel_value = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = CFG_AND_LOGIC;
    cfg_ch.data           = '0;
    // Shadow state matches the block right after reset.
    for (int i = 0; i < N_COND; i++) cond_table[i] = '0;
    for (int c = 0; c < N_CHAN; c++) chan_values[c] = '0;
    and_reg  = 1'b0;
    base_reg = RANGE_BASE_RST;
    step_reg = STEP_WIDTH_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_defaults_directed();
    test_and_logic();
    test_register_extremes();
    test_result_holdoff();
    test_random_phases();

    drain_block();
    if (pending_masks.size() != 0) begin
      $display("%0d mode masks never arrived", pending_masks.size());
      mismatches += pending_masks.size();
    end

    $display("Ran %0d condition writes, %0d channel updates and %0d evaluations over %0d %s",
             n_writes, n_updates, n_evals, n_settings, "register settings.");
    $display("%0d beats dropped by design, %0d masks checked (%0d with active modes), %0d %s",
             n_ignored, n_results, n_active_results, mismatches, "mismatches.");
    if (mismatches == 0) begin
      $display("PASS channel_range_mode_activation_top");
    end else begin
      $display("FAIL channel_range_mode_activation_top");
    end
    $finish;
  end

endmodule
